@@ rtl/core/ord_pkg.sv @@
// ord_pkg: shared types and constants for the object record deframer
// holds the result kind codes, the result record struct and the queue depth default
// used by every module of the block and by its checker
`default_nettype none

package ord_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]  FIRST_MARKER = 8'h01;
  localparam logic [7:0]  ZERO_BYTE    = 8'h00;
  localparam logic [15:0] HEADER_LEN   = 16'd4;

  typedef enum logic [2:0] {
    K_BODY   = 3'd0,
    K_OK     = 3'd1,
    K_BADSUM = 3'd2,
    K_BADM1  = 3'd3,
    K_BADM2  = 3'd4,
    K_BADLEN = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [15:0] offs;
    logic [15:0] rec_len;
    logic [7:0]  csum;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/object_record_deframer.sv @@
// object_record_deframer: top level of the formatted binary record deframer
// instantiates ord_front, ord_fifo and ord_back; types from ord_pkg
//
// Input channel: one stream byte per beat on in_byte_i (in_valid_i / in_ready_o).
// Output channel: at most one result per input byte (out_valid_o / out_ready_i):
// body bytes with their offset, a record-end beat telling whether the checksum
// matched, or an error beat for a bad marker or a short length. last_o marks
// record-end and error beats.
// Throughput: one byte per cycle sustained; the parser does one small state
// update per byte, so the input side is limited only by queue space.
// The parser writes a result into the queue at the edge that takes its byte; the
// output register then loads it from the queue once the register is empty or its
// beat leaves, so a stalled receiver holds results back in the queue.
// Zero bytes while hunting and header bytes give no result.
// When the receiver stalls, results collect in the queue (QueueDepth entries)
// and the output register; in_ready_o drops only once the queue is full.
// Reset (rst_ni low) puts the parser in hunting, clears the sum, length and
// offset counters and empties the queue and output register.
`default_nettype none

module object_record_deframer #(
  parameter int unsigned QueueDepth = ord_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_byte_o,
  output logic [15:0]      offset_o,
  output logic [15:0]      record_length_o,
  output logic [7:0]       computed_checksum_o,
  output logic             last_o
);

  logic             push;
  logic             push_ready;
  ord_pkg::result_t push_data;
  logic             pop;
  logic             pop_valid;
  ord_pkg::result_t pop_data;
  ord_pkg::result_t out_data;

  ord_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_byte_i    (in_byte_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  ord_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data)
  );

  ord_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_data_i    (pop_data),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign kind_o              = out_data.kind;
  assign data_byte_o         = out_data.data;
  assign offset_o            = out_data.offs;
  assign record_length_o     = out_data.rec_len;
  assign computed_checksum_o = out_data.csum;
  assign last_o              = out_data.last;

endmodule

`default_nettype wire

@@ rtl/core/ord_fifo.sv @@
// ord_fifo: short register queue between the record parser and the output stage
// depends on ord_pkg for the result record type
`default_nettype none

module ord_fifo #(
  parameter int unsigned Depth = ord_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  ord_pkg::result_t     push_data_i,
  output logic                 push_ready_o,
  input  wire logic            pop_i,
  output logic                 pop_valid_o,
  output ord_pkg::result_t     pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ord_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  assign do_push = push_i & push_ready_o;
  assign do_pop  = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ord_front.sv @@
// ord_front: accepts stream bytes, tracks the record framing and builds result records
// depends on ord_pkg for kind codes and the result record type
`default_nettype none

module ord_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             in_ready_o,
  output logic             push_o,
  output ord_pkg::result_t push_data_o,
  input  wire logic        push_ready_i
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_MARK2 = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_BODY  = 3'd4,
    PH_CHECK = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;

  logic             accept;
  logic             emit;
  ord_pkg::result_t res;
  logic [15:0]      len_full;
  logic [15:0]      body_len;
  logic [16:0]      cnt_inc;
  logic [7:0]       expect_sum;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  assign len_full   = {in_byte_i, len_q[7:0]};
  assign body_len   = len_q - ord_pkg::HEADER_LEN;
  assign cnt_inc    = {1'b0, cnt_q} + 17'd1;
  assign expect_sum = 8'd0 - sum_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    emit    = 1'b0;
    res     = '{kind: ord_pkg::K_BODY, data: in_byte_i, offs: 16'd0,
                rec_len: 16'd0, csum: 8'd0, last: 1'b0};
    if (accept) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (in_byte_i == ord_pkg::FIRST_MARKER) begin
            sum_d   = 8'd1;
            phase_d = PH_MARK2;
          end else if (in_byte_i != ord_pkg::ZERO_BYTE) begin
            emit     = 1'b1;
            res.kind = ord_pkg::K_BADM1;
            res.last = 1'b1;
          end
        end
        PH_MARK2: begin
          if (in_byte_i != ord_pkg::ZERO_BYTE) begin
            emit     = 1'b1;
            res.kind = ord_pkg::K_BADM2;
            res.last = 1'b1;
            phase_d  = PH_HUNT;
          end else begin
            phase_d = PH_LENLO;
          end
        end
        PH_LENLO: begin
          len_d   = {8'd0, in_byte_i};
          sum_d   = sum_q + in_byte_i;
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d = len_full;
          sum_d = sum_q + in_byte_i;
          cnt_d = 16'd0;
          if (len_full < ord_pkg::HEADER_LEN) begin
            emit        = 1'b1;
            res.kind    = ord_pkg::K_BADLEN;
            res.rec_len = len_full;
            res.last    = 1'b1;
            phase_d     = PH_HUNT;
          end else if (len_full == ord_pkg::HEADER_LEN) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          emit        = 1'b1;
          res.offs    = cnt_q;
          res.rec_len = len_q;
          sum_d       = sum_q + in_byte_i;
          cnt_d       = cnt_inc[15:0];
          if (cnt_inc >= {1'b0, body_len}) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          emit        = 1'b1;
          res.kind    = (in_byte_i == expect_sum) ? ord_pkg::K_OK : ord_pkg::K_BADSUM;
          res.rec_len = len_q;
          res.csum    = expect_sum;
          res.last    = 1'b1;
          phase_d     = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  assign push_o      = emit;
  assign push_data_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
      sum_q   <= 8'd0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ord_back.sv @@
// ord_back: output register that drains the result queue onto the output channel
// depends on ord_pkg for the result record type
`default_nettype none

module ord_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  ord_pkg::result_t q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output ord_pkg::result_t out_data_o
);

  logic             valid_q;
  ord_pkg::result_t data_q;

  // refill whenever the register is empty or its beat leaves this cycle
  assign q_pop_o     = q_valid_i & (~valid_q | out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q <= q_data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ord_checker.sv @@
// ord_checker: port-level assertions for object_record_deframer, bound to the top level
// depends on ord_pkg for the kind codes
`default_nettype none

module ord_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [2:0]  kind_o,
  input wire logic [7:0]  data_byte_o,
  input wire logic [15:0] offset_o,
  input wire logic [15:0] record_length_o,
  input wire logic [7:0]  computed_checksum_o,
  input wire logic        last_o
);

  // a stalled result beat keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(data_byte_o) && $stable(offset_o) && $stable(record_length_o)
      && $stable(computed_checksum_o) && $stable(last_o))
    else $error("output beat changed while stalled");

  // record end and error beats carry last and a zero offset
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o != ord_pkg::K_BODY))
      && (kind_o == ord_pkg::K_BODY || offset_o == 16'd0))
    else $error("last or offset does not match result kind");

  // the input only stalls behind a full queue, so a beat is waiting
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output beat pending");

  a_marker_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == ord_pkg::K_BADM1 || kind_o == ord_pkg::K_BADM2)
      |-> record_length_o == 16'd0 && computed_checksum_o == 8'd0)
    else $error("marker error beat carries length or checksum");

  // a body offset always lies inside the body length
  a_body_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == ord_pkg::K_BODY
      |-> {1'b0, offset_o} + 17'd4 < {1'b0, record_length_o})
    else $error("body offset beyond record length");

endmodule

bind object_record_deframer ord_checker u_ord_checker (.*);

`default_nettype wire

@@ test/object_record_deframer_tb.sv @@
// object_record_deframer_tb: self-checking bench for the object record deframer
// feeds directed and random byte streams, predicts every result beat in-bench
// depends on ord_pkg and the object_record_deframer rtl
`timescale 1ns / 1ps

module object_record_deframer_tb;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  localparam int FEED_TARGET  = 550;
  localparam int PAUSE_EVERY  = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_WAIT     = 4;

  localparam ord_pkg::result_t NO_BEAT = '0;

  typedef enum logic [2:0] {
    ST_SEEK, ST_MARK0, ST_LEN_LO, ST_LEN_HI, ST_BODY, ST_SUM
  } deframe_st_e;

  typedef struct {
    logic [7:0]       b;
    bit               fixed;     // expectation typed in below
    bit               has_beat;
    ord_pkg::result_t beat;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  kind_o;
  logic [7:0]  data_byte_o;
  logic [15:0] offset_o;
  logic [15:0] record_length_o;
  logic [7:0]  computed_checksum_o;
  logic        last_o;

  // predictor state
  deframe_st_e st;
  logic [15:0] rec_len_q;
  logic [15:0] body_idx;
  logic [7:0]  sum_q;

  ord_pkg::result_t expected_beats[$];
  int               mismatches;
  int               bytes_fed;
  int               cycle_count;
  int unsigned      ready_hold;
  bit               in_burst;
  bit               out_burst;

  stim_row_t directed_rows [24];

  object_record_deframer dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .in_byte_i           (in_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .data_byte_o         (data_byte_o),
    .offset_o            (offset_o),
    .record_length_o     (record_length_o),
    .computed_checksum_o (computed_checksum_o),
    .last_o              (last_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic bit deframe_byte(input logic [7:0] b, output ord_pkg::result_t r);
    logic [7:0] want;
    bit         emits;
    r = NO_BEAT;
    emits = 1'b0;
    case (st)
      ST_SEEK: begin
        if (b == ord_pkg::FIRST_MARKER) begin
          sum_q = 8'd1;
          st = ST_MARK0;
        end else if (b != ord_pkg::ZERO_BYTE) begin
          r.kind = ord_pkg::K_BADM1;
          r.data = b;
          r.last = 1'b1;
          emits = 1'b1;
        end
      end
      ST_MARK0: begin
        if (b == ord_pkg::ZERO_BYTE) begin
          st = ST_LEN_LO;
        end else begin
          st = ST_SEEK;
          r.kind = ord_pkg::K_BADM2;
          r.data = b;
          r.last = 1'b1;
          emits = 1'b1;
        end
      end
      ST_LEN_LO: begin
        rec_len_q = {8'h00, b};
        sum_q = sum_q + b;
        st = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        rec_len_q[15:8] = b;
        sum_q = sum_q + b;
        body_idx = '0;
        if (rec_len_q < ord_pkg::HEADER_LEN) begin
          st = ST_SEEK;
          r.kind = ord_pkg::K_BADLEN;
          r.data = b;
          r.rec_len = rec_len_q;
          r.last = 1'b1;
          emits = 1'b1;
        end else begin
          st = (rec_len_q == ord_pkg::HEADER_LEN) ? ST_SUM : ST_BODY;
        end
      end
      ST_BODY: begin
        r.kind = ord_pkg::K_BODY;
        r.data = b;
        r.offs = body_idx;
        r.rec_len = rec_len_q;
        emits = 1'b1;
        sum_q = sum_q + b;
        body_idx = body_idx + 16'd1;
        if (body_idx >= rec_len_q - ord_pkg::HEADER_LEN) st = ST_SUM;
      end
      default: begin
        // checksum byte closes the record
        want = 8'd0 - sum_q;
        st = ST_SEEK;
        r.kind = (b == want) ? ord_pkg::K_OK : ord_pkg::K_BADSUM;
        r.data = b;
        r.rec_len = rec_len_q;
        r.csum = want;
        r.last = 1'b1;
        emits = 1'b1;
      end
    endcase
    return emits;
  endfunction

  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] seen);
    if (seen !== want) begin
      $display("%0t mismatch on %s: expected %0h, actual %0h", $time, name, want, seen);
      mismatches++;
    end
  endfunction

  // caller sits on a rising edge; returns on the edge that takes the beat
  task automatic put_byte(input logic [7:0] b, output bit got, output ord_pkg::result_t r);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!(st == ST_SEEK && b == ord_pkg::ZERO_BYTE)) bytes_fed++;
    got = deframe_byte(b, r);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  // receiver: stalls a random number of cycles after each beat
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
      if (ready_hold == 0) out_ready_i <= 1'b1;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        $display("%0t unexpected beat: kind %0d data %0h offset %0h", $time, kind_o,
                 data_byte_o, offset_o);
        mismatches++;
      end else begin
        cmp_field("kind", 16'(expected_beats[0].kind), 16'(kind_o));
        cmp_field("data_byte", 16'(expected_beats[0].data), 16'(data_byte_o));
        cmp_field("offset", expected_beats[0].offs, offset_o);
        cmp_field("record_length", expected_beats[0].rec_len, record_length_o);
        cmp_field("computed_checksum", 16'(expected_beats[0].csum),
                  16'(computed_checksum_o));
        cmp_field("last", 16'(expected_beats[0].last), 16'(last_o));
        void'(expected_beats.pop_front());
      end
      ready_hold = out_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (ready_hold != 0) out_ready_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [7:0]       seq[$];
    logic [7:0]       acc;
    logic [7:0]       bb;
    logic [15:0]      len;
    int               pick;
    int               next_pause;
    bit               got;
    ord_pkg::result_t r;

    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_byte_i   = 8'h00;
    out_ready_i = 1'b1;
    ready_hold  = 0;
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    mismatches  = 0;
    bytes_fed   = 0;
    cycle_count = 0;
    st          = ST_SEEK;
    rec_len_q   = '0;
    body_idx    = '0;
    sum_q       = '0;

    directed_rows = '{
      // zero skipped, stray byte, bad second marker
      '{8'h00, 1'b1, 1'b0, NO_BEAT},
      '{8'hFF, 1'b1, 1'b1, '{ord_pkg::K_BADM1, 8'hFF, 16'd0, 16'd0, 8'd0, 1'b1}},
      '{8'h01, 1'b1, 1'b0, NO_BEAT},
      '{8'h80, 1'b1, 1'b1, '{ord_pkg::K_BADM2, 8'h80, 16'd0, 16'd0, 8'd0, 1'b1}},
      // short length at the boundary, then length zero
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h03, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b1, 1'b1, '{ord_pkg::K_BADLEN, 8'h00, 16'd0, 16'd3, 8'd0, 1'b1}},
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b1, 1'b1, '{ord_pkg::K_BADLEN, 8'h00, 16'd0, 16'd0, 8'd0, 1'b1}},
      // empty body, good checksum
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h04, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'hFB, 1'b1, 1'b1, '{ord_pkg::K_OK, 8'hFB, 16'd0, 16'd4, 8'hFB, 1'b1}},
      // two body bytes, bad checksum
      '{8'h01, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'h06, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b0, 1'b0, NO_BEAT},
      '{8'hAA, 1'b0, 1'b0, NO_BEAT},
      '{8'h55, 1'b0, 1'b0, NO_BEAT},
      '{8'h00, 1'b1, 1'b1, '{ord_pkg::K_BADSUM, 8'h00, 16'd0, 16'd6, 8'hFA, 1'b1}}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      put_byte(directed_rows[i].b, got, r);
      if (directed_rows[i].fixed) begin
        if (directed_rows[i].has_beat) expected_beats.push_back(directed_rows[i].beat);
      end else if (got) begin
        expected_beats.push_back(r);
      end
    end
    hold_until_drained();

    next_pause = PAUSE_EVERY;
    while (bytes_fed < FEED_TARGET) begin
      seq.delete();
      in_burst  = ($urandom_range(0, 5) == 0);
      out_burst = ($urandom_range(0, 5) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // well-formed record, mostly short, sometimes with a corrupted checksum byte
        if ($urandom_range(0, 3) == 0) seq.push_back(ord_pkg::ZERO_BYTE);
        len = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 600))
                                           : 16'($urandom_range(4, 24));
        seq.push_back(ord_pkg::FIRST_MARKER);
        seq.push_back(ord_pkg::ZERO_BYTE);
        seq.push_back(len[7:0]);
        seq.push_back(len[15:8]);
        acc = 8'd1 + len[7:0] + len[15:8];
        for (int k = 0; k < int'(len) - 4; k++) begin
          case ($urandom_range(0, 9))
            0:       bb = 8'h00;
            1:       bb = 8'hFF;
            default: bb = 8'($urandom);
          endcase
          seq.push_back(bb);
          acc = acc + bb;
        end
        bb = 8'd0 - acc;
        if ($urandom_range(0, 4) == 0) bb = bb ^ 8'($urandom_range(1, 255));
        seq.push_back(bb);
      end else if (pick < 80) begin
        // noise, mostly while hunting, never a first marker
        repeat ($urandom_range(1, 3))
          seq.push_back(($urandom_range(0, 2) == 0) ? ord_pkg::ZERO_BYTE
                                                    : 8'($urandom_range(2, 255)));
      end else if (pick < 88) begin
        seq.push_back(ord_pkg::FIRST_MARKER);
        seq.push_back(8'($urandom_range(1, 255)));
      end else if (pick < 96) begin
        seq.push_back(ord_pkg::FIRST_MARKER);
        seq.push_back(ord_pkg::ZERO_BYTE);
        seq.push_back(8'($urandom_range(0, 3)));
        seq.push_back(ord_pkg::ZERO_BYTE);
      end else begin
        // header cut after the low length byte, the next byte lands as the high byte
        seq.push_back(ord_pkg::FIRST_MARKER);
        seq.push_back(ord_pkg::ZERO_BYTE);
        seq.push_back(8'($urandom));
      end
      foreach (seq[k]) begin
        put_byte(seq[k], got, r);
        if (got) expected_beats.push_back(r);
      end
      if (bytes_fed >= next_pause) begin
        hold_until_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    hold_until_drained();
    out_burst = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
